// ===== hdl/sssp_pkg.sv =====
// ---------------------------------------------------------------------------
// sssp_pkg
// Shared constants, types and the microcode program of the state-space
// plant step block.
// ---------------------------------------------------------------------------
package sssp_pkg;

    localparam int STATE_COUNT_DEF  = 8;
    localparam int OUTPUT_COUNT_DEF = 2;
    localparam int COEF_DEPTH_DEF   = 128;

    localparam int SIG_W   = 32;
    localparam int COEF_W  = 32;
    localparam int INDEX_W = 7;
    localparam int ACT_W   = 2;
    localparam int STEP_W  = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_STEP  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_MACX,
        OP_MACU,
        OP_NOP,
        OP_FIN_Y,
        OP_FIN_X,
        OP_COMMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_START,
        C_J_MORE,
        C_I_OUT,
        C_I_ST,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic valid;
        logic finish;
    } mac_ctl_t;

    localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_OUT_ROW = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ST_ROW  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_COMMIT  = 4'd11;
    localparam logic [STEP_W-1:0] PROG_LEN     = 4'd13;

    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
        case (step)
            4'd0:  cw = '{op: OP_WAIT,   cond: C_NO_START, target: STEP_IDLE};
            4'd1:  cw = '{op: OP_MACX,   cond: C_J_MORE,   target: STEP_OUT_ROW};
            4'd2:  cw = '{op: OP_MACU,   cond: C_NONE,     target: STEP_IDLE};
            4'd3:  cw = '{op: OP_NOP,    cond: C_NONE,     target: STEP_IDLE};
            4'd4:  cw = '{op: OP_NOP,    cond: C_NONE,     target: STEP_IDLE};
            4'd5:  cw = '{op: OP_FIN_Y,  cond: C_I_OUT,    target: STEP_OUT_ROW};
            4'd6:  cw = '{op: OP_MACX,   cond: C_J_MORE,   target: STEP_ST_ROW};
            4'd7:  cw = '{op: OP_MACU,   cond: C_NONE,     target: STEP_IDLE};
            4'd8:  cw = '{op: OP_NOP,    cond: C_NONE,     target: STEP_IDLE};
            4'd9:  cw = '{op: OP_NOP,    cond: C_NONE,     target: STEP_IDLE};
            4'd10: cw = '{op: OP_FIN_X,  cond: C_I_ST,     target: STEP_ST_ROW};
            4'd11: cw = '{op: OP_COMMIT, cond: C_OUT_BUSY, target: STEP_COMMIT};
            4'd12: cw = '{op: OP_NOP,    cond: C_ALWAYS,   target: STEP_IDLE};
            default: cw = '{op: OP_NOP,  cond: C_ALWAYS,   target: STEP_IDLE};
        endcase
        return cw;
    endfunction

endpackage

// ===== hdl/sssp_mac.sv =====
// ---------------------------------------------------------------------------
// sssp_mac
// Shared multiply-accumulate unit: Q8.24 x Q16.16 products summed exactly,
// then rounded to nearest Q16.16 and saturated to 32 bits.
// ---------------------------------------------------------------------------
module sssp_mac #(
    parameter int STATE_COUNT = sssp_pkg::STATE_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sssp_pkg::mac_ctl_t                  ctl,
    input  logic signed [sssp_pkg::COEF_W-1:0]  coef,
    input  logic signed [sssp_pkg::SIG_W-1:0]   sig,
    output logic        [sssp_pkg::SIG_W-1:0]   res,
    output logic                                res_sat
);

    localparam int PROD_W = sssp_pkg::COEF_W + sssp_pkg::SIG_W;
    localparam int ACC_W  = PROD_W + $clog2(STATE_COUNT + 2);
    localparam int SHR_W  = ACC_W - 24;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [SHR_W-1:0]  shr;
    logic                     over_hi;
    logic                     over_lo;

    always_comb
    begin
        if (ctl.finish)
            acc_next = '0;
        else if (prod_vld_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctl.valid;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * sig;
    end

    // round half up, drop 24 fraction bits, clip to 32 bits
    always_comb
    begin
        rnd     = acc_reg + ACC_W'(25'sh80_0000);
        shr     = SHR_W'(rnd >>> 24);
        over_hi = shr > SHR_W'(33'sh0_7FFF_FFFF);
        over_lo = shr < -SHR_W'(33'sh0_8000_0000);
        if (over_hi)
            res = 32'h7FFF_FFFF;
        else if (over_lo)
            res = 32'h8000_0000;
        else
            res = shr[sssp_pkg::SIG_W-1:0];
        res_sat = over_hi | over_lo;
    end

`ifndef SYNTHESIS
    a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> !prod_vld_reg && !ctl.valid)
        else $error("accumulator read while a product is in flight");
`endif

endmodule

// ===== hdl/state_space_plant_step_top.sv =====
// ---------------------------------------------------------------------------
// state_space_plant_step_top
// Discrete state-space plant step: y = C*x + D*u, then x = A*x + B*u,
// driven by a microcoded sequencer over one shared MAC.
// ---------------------------------------------------------------------------
// channel  dir  tdata                                 tuser
// s_*      in   drive_current, coef_index, coef_value action
// m_*      out  motor_position, load_position         saturated
//
// Each matrix row issues S + 1 MACs, drains the MAC pipeline and then
// finishes. Coefficient write and state clear are done in the idle step
// when the word is accepted.
// rst_n clears the state vector and the sequencer; the coefficient store
// is not cleared. A held result stalls the sequencer at its commit step.
module state_space_plant_step_top #(
    parameter int STATE_COUNT  = sssp_pkg::STATE_COUNT_DEF,
    parameter int OUTPUT_COUNT = sssp_pkg::OUTPUT_COUNT_DEF,
    parameter int COEF_DEPTH   = sssp_pkg::COEF_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // drive_current, coef_index, coef_value, pad
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // motor_position, load_position
    output logic [0:0]  m_tuser    // saturated
);

    localparam int S      = STATE_COUNT;
    localparam int O      = OUTPUT_COUNT;
    localparam int B_BASE = S * S;
    localparam int C_BASE = B_BASE + S;
    localparam int D_BASE = C_BASE + O * S;
    localparam int PTR_W  = $clog2(D_BASE + O + 1);
    localparam int IDX_W  = $clog2(COEF_DEPTH);
    localparam int I_W    = (S > 1) ? $clog2(S) : 1;

    logic [31:0] mem [COEF_DEPTH];
    logic [31:0] rd_reg;

    logic [sssp_pkg::STEP_W-1:0] step_reg;
    logic [sssp_pkg::STEP_W-1:0] step_next;
    sssp_pkg::ctrl_word_t        cw;
    logic                        take;

    logic [I_W-1:0]   i_reg;
    logic [I_W-1:0]   j_reg;
    logic [PTR_W-1:0] row_ptr_reg;
    logic [PTR_W-1:0] u_ptr_reg;
    logic [31:0]      u_reg;
    logic [31:0]      x_reg  [S];
    logic [31:0]      nx_reg [S];
    logic [31:0]      y_reg  [2];
    logic             sat_reg;

    logic             s1_vld_reg;
    logic             s1_rng_reg;
    logic [31:0]      s1_sig_reg;

    logic             out_vld_reg;
    logic [63:0]      out_data_reg;
    logic             out_sat_reg;

    logic             accept;
    logic             start;
    logic             issue;
    logic [PTR_W-1:0] rd_ptr;
    logic [31:0]      rd_addr32;
    logic [31:0]      wr_addr32;
    logic             out_busy;
    logic             j_last;
    logic             i_last_out;
    logic             i_last_st;

    sssp_pkg::mac_ctl_t mac_ctl;
    logic [31:0]        mac_res;
    logic               mac_sat;

    assign cw         = sssp_pkg::ucode(step_reg);
    assign s_tready   = (cw.op == sssp_pkg::OP_WAIT);
    assign accept     = s_tvalid && s_tready;
    assign start      = accept && (s_tuser == sssp_pkg::ACT_STEP);
    assign out_busy   = out_vld_reg && !m_tready;
    assign j_last     = (32'(j_reg) == S - 1);
    assign i_last_out = (32'(i_reg) == O - 1);
    assign i_last_st  = (32'(i_reg) == S - 1);
    assign issue      = (cw.op == sssp_pkg::OP_MACX) || (cw.op == sssp_pkg::OP_MACU);
    assign rd_ptr     = (cw.op == sssp_pkg::OP_MACU) ? u_ptr_reg : row_ptr_reg;
    assign rd_addr32  = 32'(rd_ptr);
    assign wr_addr32  = 32'(s_tdata[38:32]);

    always_comb
    begin
        case (cw.cond)
            sssp_pkg::C_ALWAYS:   take = 1'b1;
            sssp_pkg::C_NO_START: take = !start;
            sssp_pkg::C_J_MORE:   take = !j_last;
            sssp_pkg::C_I_OUT:    take = !i_last_out;
            sssp_pkg::C_I_ST:     take = !i_last_st;
            sssp_pkg::C_OUT_BUSY: take = out_busy;
            default:              take = 1'b0;
        endcase
        step_next = take ? cw.target : step_reg + 1'b1;
    end

    // coefficient store
    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == sssp_pkg::ACT_WRITE && wr_addr32 < COEF_DEPTH)
            mem[wr_addr32[IDX_W-1:0]] <= s_tdata[70:39];
        rd_reg <= mem[rd_addr32[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= sssp_pkg::STEP_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < S; k++)
                x_reg[k] <= '0;
        end
        else
        begin
            step_reg   <= step_next;
            s1_vld_reg <= issue;
            if (out_vld_reg && m_tready && cw.op != sssp_pkg::OP_COMMIT)
                out_vld_reg <= 1'b0;
            unique case (cw.op)
                sssp_pkg::OP_WAIT:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                    if (accept && s_tuser == sssp_pkg::ACT_CLEAR)
                        for (int k = 0; k < S; k++)
                            x_reg[k] <= '0;
                end
                sssp_pkg::OP_MACX:
                    j_reg <= j_last ? '0 : j_reg + 1'b1;
                sssp_pkg::OP_FIN_Y:
                    i_reg <= i_last_out ? '0 : i_reg + 1'b1;
                sssp_pkg::OP_FIN_X:
                    i_reg <= i_last_st ? '0 : i_reg + 1'b1;
                sssp_pkg::OP_COMMIT:
                begin
                    if (!out_busy)
                    begin
                        out_vld_reg <= 1'b1;
                        for (int k = 0; k < S; k++)
                            x_reg[k] <= nx_reg[k];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        s1_rng_reg <= rd_addr32 < COEF_DEPTH;
        s1_sig_reg <= (cw.op == sssp_pkg::OP_MACU) ? u_reg : x_reg[j_reg];
        unique case (cw.op)
            sssp_pkg::OP_WAIT:
            begin
                if (start)
                begin
                    u_reg       <= s_tdata[31:0];
                    row_ptr_reg <= PTR_W'(C_BASE);
                    u_ptr_reg   <= PTR_W'(D_BASE);
                    sat_reg     <= 1'b0;
                    y_reg[1]    <= '0;
                end
            end
            sssp_pkg::OP_MACX:
                row_ptr_reg <= row_ptr_reg + 1'b1;
            sssp_pkg::OP_MACU:
                u_ptr_reg <= u_ptr_reg + 1'b1;
            sssp_pkg::OP_FIN_Y:
            begin
                y_reg[i_reg[0]] <= mac_res;
                sat_reg         <= sat_reg | mac_sat;
                if (i_last_out)
                begin
                    row_ptr_reg <= '0;
                    u_ptr_reg   <= PTR_W'(B_BASE);
                end
            end
            sssp_pkg::OP_FIN_X:
            begin
                nx_reg[i_reg] <= mac_res;
                sat_reg       <= sat_reg | mac_sat;
            end
            sssp_pkg::OP_COMMIT:
            begin
                if (!out_busy)
                begin
                    out_data_reg <= {y_reg[1], y_reg[0]};
                    out_sat_reg  <= sat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign mac_ctl.valid  = s1_vld_reg;
    assign mac_ctl.finish = (cw.op == sssp_pkg::OP_FIN_Y) || (cw.op == sssp_pkg::OP_FIN_X);

    sssp_mac #(
        .STATE_COUNT (STATE_COUNT)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .coef    (s1_rng_reg ? rd_reg : 32'h0),
        .sig     (s1_sig_reg),
        .res     (mac_res),
        .res_sat (mac_sat)
    );

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sat_reg;

`ifndef SYNTHESIS
    a_rose_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cw.op == sssp_pkg::OP_COMMIT))
        else $error("result word raised outside the commit step");

    a_fin_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == sssp_pkg::OP_FIN_Y || cw.op == sssp_pkg::OP_FIN_X) |-> !s1_vld_reg)
        else $error("finish step while a MAC is still in the pipe");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < sssp_pkg::PROG_LEN)
        else $error("step counter left the program");

    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == sssp_pkg::OP_MACX) && $past(cw.op == sssp_pkg::OP_WAIT) |->
            j_reg == '0 && i_reg == '0)
        else $error("row counters not cleared at the start of a step");
`endif

endmodule
